// File: rtl/core/vertical_ray_face_intersect_macros.svh
// Assertion macros for the vertical ray face intersect RTL.
// No dependencies; included by the top-level module, which carries the assertions.
`ifndef VERTICAL_RAY_FACE_INTERSECT_MACROS_SVH
`define VERTICAL_RAY_FACE_INTERSECT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VRFI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vertical_ray_face_intersect: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define VRFI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vertical_ray_face_intersect: next-cycle check failed");

`endif

// File: rtl/core/vrfi_pkg.sv
// Package for the vertical ray face intersect block: constants, word codes,
// register indexes and the sequencer state type. No dependencies.
`default_nettype none

package vrfi_pkg;

    localparam int MAX_FACES_DEF  = 64;
    localparam int WORDS_PER_FACE = 16;
    localparam int WORD_BITS      = 32;
    localparam int TOLERANCE      = 'h80;
    localparam int FRACTION_ONE   = 'h0800_0000;
    localparam int ROUND_HALF     = 'h800;
    localparam int FRACTION_BITS  = 27;
    localparam int FIXED_BITS     = 12;

    // Face word codes.
    localparam logic [3:0] W_MIN_X    = 4'd0;
    localparam logic [3:0] W_FLAGS    = 4'd4;
    localparam logic [3:0] W_PLANE_XY = 4'd5;
    localparam logic [3:0] W_PLANE_Z  = 4'd6;
    localparam logic [3:0] W_DIST     = 4'd7;
    localparam logic [3:0] W_EDGE0    = 4'd8;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FACE_COUNT = 2'd0;
    localparam logic [1:0] CFG_SKIP_MASK  = 2'd1;
    localparam logic [1:0] CFG_VERT_MASK  = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FACE,
        S_W4,
        S_BND,
        S_P5,
        S_P6,
        S_PY0,
        S_PY1,
        S_PEV,
        S_DIST,
        S_MULN,
        S_NEAR,
        S_EW,
        S_EZ,
        S_ED,
        S_DIV,
        S_MULY,
        S_ACC,
        S_NEXT,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// File: rtl/core/vrfi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on vrfi_pkg for default sizes.
`default_nettype none

module vrfi_ram
    import vrfi_pkg::*;
#(
    parameter int WIDTH = WORD_BITS,
    parameter int DEPTH = MAX_FACES_DEF * WORDS_PER_FACE,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/vertical_ray_face_intersect.sv
// Top level of the vertical ray face intersect block: face store, sequencer,
// shared multiplier and bit-serial divider. Depends on vrfi_pkg, vrfi_ram.
//
//   channel   direction  handshake          payload
//   command   in         start, busy        i_kind, i_face_slot, i_word_select,
//                                           i_word_data, i_pos_x, i_pos_z,
//                                           i_start_y, i_end_y
//   result    out        o_strobe           o_hit, o_hit_face, o_hit_fraction, o_hit_y
//   config    in         i_cfg_we           i_cfg_index, i_cfg_data
//
// A word write leaves busy low. A query holds busy high while it walks the faces
// in turn, using the one-bit-a-cycle divider and the single 33x29 multiplier; no
// command is taken until it is done. o_strobe is high in the first cycle with busy low.
// Synchronous active-low reset clears the sequencer, the strobe and the configuration
// registers; the face store and the datapath registers are not cleared. The receiver
// cannot stall the result.
`default_nettype none

`include "vertical_ray_face_intersect_macros.svh"

module vertical_ray_face_intersect
    import vrfi_pkg::*;
#(
    parameter int MAX_FACES = MAX_FACES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_kind,
    input  wire logic [5:0]         i_face_slot,
    input  wire logic [3:0]         i_word_select,
    input  wire logic [31:0]        i_word_data,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_z,
    input  wire logic signed [31:0] i_start_y,
    input  wire logic signed [31:0] i_end_y,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data,
    output logic                    o_strobe,
    output logic                    o_hit,
    output logic [5:0]              o_hit_face,
    output logic [27:0]             o_hit_fraction,
    output logic signed [31:0]      o_hit_y
);

    localparam int FIW   = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
    localparam int CW    = $clog2(MAX_FACES + 1);
    localparam int AW    = FIW + 4;
    localparam int DEPTH = MAX_FACES * WORDS_PER_FACE;

    localparam logic signed [32:0] TOL33 = 33'(TOLERANCE);
    localparam logic [27:0]        ONE28 = 28'(FRACTION_ONE);

    function automatic logic signed [31:0] round_fx(input logic [43:0] s);
        logic [43:0] t;
        t = s + 44'(ROUND_HALF);
        return $signed(t[43:FIXED_BITS]);
    endfunction

    function automatic logic signed [28:0] sx16(input logic [15:0] v);
        return $signed({{13{v[15]}}, v});
    endfunction

    // Configuration registers.
    logic [6:0]  r_face_count;
    logic [15:0] r_skip_mask;
    logic [15:0] r_vert_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_count <= 7'd0;
            r_skip_mask  <= 16'd1;
            r_vert_mask  <= 16'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FACE_COUNT: r_face_count <= i_cfg_data[6:0];
                CFG_SKIP_MASK:  r_skip_mask  <= i_cfg_data;
                CFG_VERT_MASK:  r_vert_mask  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    t_state r_state, n_state;
    logic [CW-1:0]      r_face, n_face;
    logic [1:0]         r_sub, n_sub;
    logic [4:0]         r_cnt, n_cnt;
    logic signed [31:0] r_x, n_x, r_z, n_z, r_y0, n_y0, r_y1, n_y1;
    logic signed [32:0] r_dy, n_dy;
    logic               r_vert, n_vert, r_quad, n_quad;
    logic [15:0]        r_py, n_py, r_ez, n_ez;
    logic [43:0]        r_acc, n_acc;
    logic signed [61:0] r_prod;
    logic signed [31:0] r_sv, n_sv, r_ev, n_ev;
    logic signed [32:0] r_above, n_above, r_span, n_span;
    logic [33:0]        r_rem, n_rem;
    logic [27:0]        r_q, n_q;
    logic [27:0]        r_best_frac, n_best_frac;
    logic [FIW-1:0]     r_best_face, n_best_face;
    logic [31:0]        r_best_y, n_best_y;
    logic               r_hit, n_hit;
    logic               r_strobe, n_strobe;
    logic               r_out_hit, n_out_hit;
    logic [5:0]         r_out_face, n_out_face;
    logic [27:0]        r_out_frac, n_out_frac;
    logic [31:0]        r_out_y, n_out_y;

    logic signed [32:0] mul_a;
    logic signed [28:0] mul_b;
    logic [3:0]         rd_word;
    logic [31:0]        rdata;
    logic               ram_we;
    logic [CW-1:0]      limit;
    logic [43:0]        sum;
    logic signed [31:0] rnd;
    logic signed [32:0] x33, z33, sv33, ev33, dat33, above, below, span34_lo;
    logic [33:0]        span34, rem2;
    logic               fail;
    logic [1:0]         last_edge;

    assign busy   = (r_state != S_IDLE);
    assign ram_we = start && !busy && !i_kind && (32'(i_face_slot) < MAX_FACES);
    assign limit  = (32'(r_face_count) > MAX_FACES) ? CW'(MAX_FACES) : CW'(r_face_count);

    vrfi_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr ({FIW'(i_face_slot), i_word_select}),
        .i_wdata (i_word_data),
        .i_raddr ({r_face[FIW-1:0], rd_word}),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_face      <= n_face;
        r_sub       <= n_sub;
        r_cnt       <= n_cnt;
        r_x         <= n_x;
        r_z         <= n_z;
        r_y0        <= n_y0;
        r_y1        <= n_y1;
        r_dy        <= n_dy;
        r_vert      <= n_vert;
        r_quad      <= n_quad;
        r_py        <= n_py;
        r_ez        <= n_ez;
        r_acc       <= n_acc;
        r_prod      <= mul_a * mul_b;
        r_sv        <= n_sv;
        r_ev        <= n_ev;
        r_above     <= n_above;
        r_span      <= n_span;
        r_rem       <= n_rem;
        r_q         <= n_q;
        r_best_frac <= n_best_frac;
        r_best_face <= n_best_face;
        r_best_y    <= n_best_y;
        r_hit       <= n_hit;
        r_out_hit   <= n_out_hit;
        r_out_face  <= n_out_face;
        r_out_frac  <= n_out_frac;
        r_out_y     <= n_out_y;
    end

    always_comb begin
        n_state     = r_state;
        n_face      = r_face;
        n_sub       = r_sub;
        n_cnt       = r_cnt;
        n_x         = r_x;
        n_z         = r_z;
        n_y0        = r_y0;
        n_y1        = r_y1;
        n_dy        = r_dy;
        n_vert      = r_vert;
        n_quad      = r_quad;
        n_py        = r_py;
        n_ez        = r_ez;
        n_acc       = r_acc;
        n_sv        = r_sv;
        n_ev        = r_ev;
        n_above     = r_above;
        n_span      = r_span;
        n_rem       = r_rem;
        n_q         = r_q;
        n_best_frac = r_best_frac;
        n_best_face = r_best_face;
        n_best_y    = r_best_y;
        n_hit       = r_hit;
        n_strobe    = 1'b0;
        n_out_hit   = r_out_hit;
        n_out_face  = r_out_face;
        n_out_frac  = r_out_frac;
        n_out_y     = r_out_y;
        mul_a       = '0;
        mul_b       = '0;
        rd_word     = W_FLAGS;

        x33       = {r_x[31], r_x};
        z33       = {r_z[31], r_z};
        sv33      = {r_sv[31], r_sv};
        ev33      = {r_ev[31], r_ev};
        dat33     = $signed({rdata[31], rdata});
        above     = sv33 - dat33;
        below     = ev33 - dat33;
        span34_lo = sv33 - ev33;
        span34    = {1'b0, r_span};
        rem2      = {r_rem[32:0], 1'b0};
        sum       = r_acc + r_prod[43:0];
        rnd       = round_fx(sum);
        last_edge = r_quad ? 2'd3 : 2'd2;
        fail      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start && i_kind) begin
                    n_x         = i_pos_x;
                    n_z         = i_pos_z;
                    n_y0        = i_start_y;
                    n_y1        = i_end_y;
                    n_dy        = {i_end_y[31], i_end_y} - {i_start_y[31], i_start_y};
                    n_face      = '0;
                    n_hit       = 1'b0;
                    n_best_frac = ONE28;
                    n_best_face = '0;
                    n_best_y    = '0;
                    n_state     = S_FACE;
                end
            end
            S_FACE: begin
                if (r_face >= limit) begin
                    n_state = S_DONE;
                end else begin
                    rd_word = W_FLAGS;
                    n_state = S_W4;
                end
            end
            S_W4: begin
                if ((rdata[15:0] & r_skip_mask) != 16'd0) begin
                    n_state = S_NEXT;
                end else begin
                    n_vert  = |(rdata[15:0] & r_vert_mask);
                    n_quad  = (rdata[31:16] == 16'd4);
                    n_sub   = 2'd0;
                    rd_word = W_MIN_X;
                    n_state = S_BND;
                end
            end
            S_BND: begin
                // Bounds come in as min x, min z, max x, max z.
                unique case (r_sub)
                    2'd0: fail = r_x < $signed(rdata);
                    2'd1: fail = r_z < $signed(rdata);
                    2'd2: fail = r_x > $signed(rdata);
                    2'd3: fail = r_z > $signed(rdata);
                endcase
                if (fail) begin
                    n_state = S_NEXT;
                end else if (r_sub != 2'd3) begin
                    n_sub   = r_sub + 2'd1;
                    rd_word = {2'b00, r_sub + 2'd1};
                end else if (r_vert) begin
                    n_sv    = r_y0;
                    n_ev    = r_y1;
                    rd_word = W_DIST;
                    n_state = S_DIST;
                end else begin
                    rd_word = W_PLANE_XY;
                    n_state = S_P5;
                end
            end
            S_P5: begin
                n_py    = rdata[31:16];
                mul_a   = x33;
                mul_b   = sx16(rdata[15:0]);
                rd_word = W_PLANE_Z;
                n_state = S_P6;
            end
            S_P6: begin
                n_acc   = r_prod[43:0];
                mul_a   = z33;
                mul_b   = sx16(rdata[15:0]);
                n_state = S_PY0;
            end
            S_PY0: begin
                n_acc   = sum;
                mul_a   = {r_y0[31], r_y0};
                mul_b   = sx16(r_py);
                n_state = S_PY1;
            end
            S_PY1: begin
                n_sv    = rnd;
                mul_a   = {r_y1[31], r_y1};
                mul_b   = sx16(r_py);
                n_state = S_PEV;
            end
            S_PEV: begin
                n_ev    = rnd;
                rd_word = W_DIST;
                n_state = S_DIST;
            end
            S_DIST: begin
                if (r_sv <= r_ev || above < -TOL33 || below > TOL33) begin
                    n_state = S_NEXT;
                end else begin
                    n_above = above;
                    n_span  = span34_lo;
                    n_state = S_MULN;
                end
            end
            S_MULN: begin
                mul_a   = r_span;
                mul_b   = $signed({1'b0, r_best_frac});
                n_state = S_NEAR;
            end
            S_NEAR: begin
                // Only a strictly nearer crossing can replace the best face.
                if ($signed({{2{r_above[32]}}, r_above}) >= $signed(r_prod[61:27])) begin
                    n_state = S_NEXT;
                end else begin
                    n_sub   = 2'd0;
                    rd_word = W_EDGE0;
                    n_state = S_EW;
                end
            end
            S_EW: begin
                n_ez    = rdata[31:16];
                mul_a   = x33;
                mul_b   = sx16(rdata[15:0]);
                n_state = S_EZ;
            end
            S_EZ: begin
                n_acc   = r_prod[43:0];
                mul_a   = z33;
                mul_b   = sx16(r_ez);
                rd_word = {1'b1, r_sub, 1'b1};
                n_state = S_ED;
            end
            S_ED: begin
                if ($signed({rnd[31], rnd}) < dat33 - TOL33) begin
                    n_state = S_NEXT;
                end else if (r_sub != last_edge) begin
                    n_sub   = r_sub + 2'd1;
                    rd_word = {1'b1, r_sub + 2'd1, 1'b0};
                    n_state = S_EW;
                end else if (r_above < 0) begin
                    n_q     = '0;
                    n_state = S_MULY;
                end else if (r_above >= r_span) begin
                    n_q     = ONE28;
                    n_state = S_MULY;
                end else begin
                    n_rem   = 34'(r_above);
                    n_q     = '0;
                    n_cnt   = 5'(FRACTION_BITS);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (rem2 >= span34) begin
                    n_rem = rem2 - span34;
                    n_q   = {r_q[26:0], 1'b1};
                end else begin
                    n_rem = rem2;
                    n_q   = {r_q[26:0], 1'b0};
                end
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    n_state = S_MULY;
                end
            end
            S_MULY: begin
                mul_a   = r_dy;
                mul_b   = $signed({1'b0, r_q});
                n_state = S_ACC;
            end
            S_ACC: begin
                n_best_y    = r_y0 + r_prod[58:27];
                n_best_frac = r_q;
                n_best_face = r_face[FIW-1:0];
                n_hit       = 1'b1;
                n_state     = S_NEXT;
            end
            S_NEXT: begin
                n_face  = r_face + CW'(1);
                n_state = S_FACE;
            end
            S_DONE: begin
                n_strobe   = 1'b1;
                n_out_hit  = r_hit;
                n_out_face = r_hit ? 6'(r_best_face) : 6'd0;
                n_out_frac = r_hit ? r_best_frac : 28'd0;
                n_out_y    = r_hit ? r_best_y : 32'd0;
                n_state    = S_IDLE;
            end
        endcase
    end

    assign o_strobe       = r_strobe;
    assign o_hit          = r_out_hit;
    assign o_hit_face     = r_out_face;
    assign o_hit_fraction = r_out_frac;
    assign o_hit_y        = $signed(r_out_y);

    `VRFI_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, start && !busy && i_kind, busy)
    `VRFI_ASSERT_NEXT(a_done_strobe, i_clk, i_rst_n, r_state == S_DONE, o_strobe && !busy)
    `VRFI_ASSERT_SAME(a_miss_zero, i_clk, i_rst_n, o_strobe && !o_hit,
        o_hit_face == 6'd0 && o_hit_fraction == 28'd0 && o_hit_y == 32'sd0)
    `VRFI_ASSERT_SAME(a_frac_range, i_clk, i_rst_n, o_strobe, o_hit_fraction <= ONE28)
    `VRFI_ASSERT_SAME(a_div_rem, i_clk, i_rst_n, r_state == S_DIV, r_rem < span34)

endmodule

`default_nettype wire

// File: tb/vertical_ray_face_intersect_tb.sv
// Self-checking testbench for vertical_ray_face_intersect: loads faces, runs ground
// queries under several register settings and checks every result item against
// an in-bench predictor. Depends on vrfi_pkg and the block itself.
`default_nettype none

module vertical_ray_face_intersect_tb;
    import vrfi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;
    localparam int   STALL_LIMIT = 40000;

    typedef struct {
        logic        kind;
        logic [5:0]  slot;
        logic [3:0]  wsel;
        logic [31:0] wdata;
        logic [31:0] x, z, y0, y1;
    } t_cmd;

    typedef struct {
        logic        hit;
        logic [5:0]  face;
        logic [27:0] frac;
        logic [31:0] y;
    } t_ground;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic i_kind = 1'b0;
    logic [5:0] i_face_slot = '0;
    logic [3:0] i_word_select = '0;
    logic [31:0] i_word_data = '0;
    logic signed [31:0] i_pos_x = '0, i_pos_z = '0, i_start_y = '0, i_end_y = '0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic o_strobe, o_hit;
    logic [5:0] o_hit_face;
    logic [27:0] o_hit_fraction;
    logic signed [31:0] o_hit_y;

    vertical_ray_face_intersect u_dut (.*);

    always #6 i_clk = ~i_clk;

    t_cmd    cmd_fifo[$];
    t_ground ground_expect[$];
    t_cmd    cur;
    logic [31:0] face_mem [0:1023];
    int unsigned face_count_reg = 0;
    logic [15:0] skip_mask_reg = 16'h1, vert_mask_reg = 16'h2;
    int errors = 0;
    int burst_left = 0, gap_left = 0, idle_cycles = 0;

    function automatic longint sx32(logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint sx16(logic [15:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint round_fx(longint sum);
        longint t;
        t = (sum + ROUND_HALF) >>> FIXED_BITS;
        return sx32(t[31:0]);
    endfunction

    // Works out the ground result of one query, or records one word write.
    function automatic void predict_ground(t_cmd c);
        longint x, z, y0, y1, best_frac, best_y, sv, ev, plane_dist, above, span, frac, v;
        longint horiz;
        int unsigned n, best_face, edges, base;
        logic [15:0] flags;
        logic [31:0] pw, ew;
        bit found, in_face;
        t_ground r;
        if (c.kind == KIND_WRITE) begin
            face_mem[{c.slot, c.wsel}] = c.wdata;
            return;
        end
        x = sx32(c.x); z = sx32(c.z); y0 = sx32(c.y0); y1 = sx32(c.y1);
        best_frac = FRACTION_ONE; best_y = 0; best_face = 0; found = 0;
        n = (face_count_reg > MAX_FACES_DEF) ? MAX_FACES_DEF : face_count_reg;
        for (int i = 0; i < n; i++) begin
            base = i * WORDS_PER_FACE;
            flags = face_mem[base + 4][15:0];
            if ((flags & skip_mask_reg) != 0) continue;
            if (x < sx32(face_mem[base]) || z < sx32(face_mem[base + 1]) ||
                x > sx32(face_mem[base + 2]) || z > sx32(face_mem[base + 3])) continue;
            if ((flags & vert_mask_reg) != 0) begin
                sv = y0; ev = y1;
            end else begin
                pw = face_mem[base + 5];
                horiz = sx16(pw[15:0]) * x + sx16(face_mem[base + 6][15:0]) * z;
                sv = round_fx(horiz + sx16(pw[31:16]) * y0);
                ev = round_fx(horiz + sx16(pw[31:16]) * y1);
            end
            if (sv <= ev) continue;
            plane_dist = sx32(face_mem[base + 7]);
            above = sv - plane_dist;
            if (above < -TOLERANCE) continue;
            if (ev - plane_dist > TOLERANCE) continue;
            span = sv - ev;
            if (above >= ((best_frac * span) >>> FRACTION_BITS)) continue;
            if (above < 0) frac = 0;
            else if (above > span) frac = FRACTION_ONE;
            else frac = (above <<< FRACTION_BITS) / span;
            edges = (face_mem[base + 4][31:16] == 16'd4) ? 4 : 3;
            in_face = 1;
            for (int e = 0; e < edges; e++) begin
                ew = face_mem[base + 8 + 2 * e];
                v = round_fx(x * sx16(ew[15:0]) + z * sx16(ew[31:16]));
                if (v < sx32(face_mem[base + 9 + 2 * e]) - TOLERANCE) begin
                    in_face = 0;
                    break;
                end
            end
            if (!in_face) continue;
            best_frac = frac; found = 1; best_face = i;
            best_y = y0 + (((y1 - y0) * frac) >>> FRACTION_BITS);
        end
        r.hit = found;
        r.face = found ? best_face[5:0] : '0;
        r.frac = found ? best_frac[27:0] : '0;
        r.y = found ? best_y[31:0] : '0;
        ground_expect = {ground_expect, r};
    endfunction

    // Command driver: bursts of items with random gaps between them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) predict_ground(cur);
            if (start && busy) begin
                // hold the item until the block takes it
            end else if (gap_left > 0) begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (cmd_fifo.size() > 0) begin
                cur = cmd_fifo.pop_front();
                start <= 1'b1;
                i_kind <= cur.kind; i_face_slot <= cur.slot; i_word_select <= cur.wsel;
                i_word_data <= cur.wdata; i_pos_x <= cur.x; i_pos_z <= cur.z;
                i_start_y <= cur.y0; i_end_y <= cur.y1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    task automatic report(string what);
        errors++;
        $display("ERROR at %0t: %s", $realtime, what);
    endtask

    // Result monitor.
    always @(posedge i_clk) begin
        t_ground e;
        if (i_rst_n && o_strobe) begin
            if (ground_expect.size() == 0) begin
                report("result item with none expected");
            end else begin
                e = ground_expect.pop_front();
                if (o_hit !== e.hit) report($sformatf("hit %b, want %b", o_hit, e.hit));
                if (o_hit_face !== e.face)
                    report($sformatf("face %0d, want %0d", o_hit_face, e.face));
                if (o_hit_fraction !== e.frac)
                    report($sformatf("fraction %h, want %h", o_hit_fraction, e.frac));
                if (o_hit_y !== e.y) report($sformatf("y %h, want %h", o_hit_y, e.y));
            end
        end
    end

    // Watchdog on cycles in which no item moves on either side.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic void push_write(int slot, int w, logic [31:0] d);
        t_cmd c;
        c = '{KIND_WRITE, slot[5:0], w[3:0], d, '0, '0, '0, '0};
        cmd_fifo = {cmd_fifo, c};
    endfunction

    function automatic void push_query(logic [31:0] x, z, y0, y1);
        t_cmd c;
        c = '{KIND_QUERY, 6'($urandom), 4'($urandom), $urandom, x, z, y0, y1};
        cmd_fifo = {cmd_fifo, c};
    endfunction

    // Loads one face. A plain face is a level floor over the whole plane that passes every
    // edge test but the fourth under edge_fail; otherwise bounds, plane and edges are randomized.
    function automatic void make_face(int slot, int h, logic [15:0] flags,
                                      logic [15:0] count, bit plain, bit edge_fail);
        logic [31:0] w [16];
        int px, pz;
        if ($urandom_range(0, 9) == 0 && !plain) begin
            foreach (w[k]) w[k] = $urandom;
        end else begin
            px = plain ? 0 : $urandom_range(0, 64) - 32;
            pz = plain ? 0 : $urandom_range(0, 64) - 32;
            w[0] = plain ? 32'h8000_0000 : -$urandom_range(0, 1 << 23);
            w[1] = plain ? 32'h8000_0000 : -$urandom_range(0, 1 << 23);
            w[2] = plain ? 32'h7fff_ffff : $urandom_range(0, 1 << 23);
            w[3] = plain ? 32'h7fff_ffff : $urandom_range(0, 1 << 23);
            w[W_FLAGS] = {count, flags};
            w[W_PLANE_XY] = {16'(plain ? 4096 : 4096 + $urandom_range(0, 512) - 256),
                             16'(px)};
            w[W_PLANE_Z] = {16'($urandom), 16'(pz)};
            w[W_DIST] = h;
            for (int e = 0; e < 4; e++) begin
                w[W_EDGE0 + 2 * e] = $urandom;
                w[W_EDGE0 + 2 * e + 1] = ($urandom_range(0, 3) != 0 || plain) ?
                                         32'h8000_0000 : $urandom_range(0, 1 << 24) - (1 << 23);
            end
            if (edge_fail) w[W_EDGE0 + 7] = 32'h7fff_ffff;
        end
        foreach (w[k]) push_write(slot, k, w[k]);
    endfunction

    function automatic void random_query();
        int y0;
        if ($urandom_range(0, 9) == 0) begin
            push_query($urandom, $urandom, $urandom, $urandom);
        end else begin
            y0 = $urandom_range(0, 1 << 24) - (1 << 22);
            push_query($urandom_range(0, 1 << 23) - (1 << 22),
                       $urandom_range(0, 1 << 23) - (1 << 22),
                       y0, ($urandom_range(0, 7) == 0) ? y0 + $urandom_range(0, 4096)
                                                       : y0 - $urandom_range(0, 1 << 24));
        end
    endfunction

    function automatic logic [15:0] random_flags();
        case ($urandom_range(0, 4))
            0, 1:    return 16'h0;
            2:       return 16'h1 << $urandom_range(0, 15);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic set_reg(logic [1:0] idx, logic [15:0] d);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= d;
        if (idx == CFG_FACE_COUNT) face_count_reg = 32'(d[6:0]);
        else if (idx == CFG_SKIP_MASK) skip_mask_reg = d;
        else if (idx == CFG_VERT_MASK) vert_mask_reg = d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (cmd_fifo.size() != 0 || start || ground_expect.size() != 0 || busy);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic random_phase(int fc, logic [15:0] skip, logic [15:0] vert, int items);
        int sent;
        set_reg(CFG_FACE_COUNT, 16'(fc));
        set_reg(CFG_SKIP_MASK, skip);
        set_reg(CFG_VERT_MASK, vert);
        sent = 0;
        while (sent < items) begin
            case ($urandom_range(0, 19))
                0: begin
                    make_face($urandom_range(0, 63), $urandom_range(0, 1 << 23) - (1 << 22),
                              random_flags(), 16'($urandom_range(2, 5)), 1'b0, 1'b0);
                    sent += 16;
                end
                1, 2, 3: begin
                    push_write($urandom_range(0, 63), $urandom_range(0, 15), $urandom);
                    sent++;
                end
                default: begin
                    random_query();
                    sent++;
                end
            endcase
        end
        drain();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every word of every face is written before any query reads it.
        make_face(0, 0, 16'h0, 16'd3, 1'b1, 1'b0);
        make_face(1, 0, 16'h0, 16'd3, 1'b1, 1'b0);        // same floor: earlier face wins
        make_face(2, 4096, 16'h1, 16'd3, 1'b1, 1'b0);     // skipped by the reset mask
        make_face(3, 32'h1000, 16'h2, 16'd4, 1'b1, 1'b0); // raw y as plane value
        make_face(4, 8192, 16'h0, 16'd4, 1'b1, 1'b1);     // quad, last edge rejects
        for (int s = 5; s < 64; s++)
            make_face(s, $urandom_range(0, 1 << 23) - (1 << 22), random_flags(),
                      16'($urandom_range(2, 5)), 1'b0, 1'b0);
        drain();

        set_reg(CFG_FACE_COUNT, 16'd8);
        push_query(0, 0, 32'h0001_0000, 32'hffff_0000);
        push_query(0, 0, 32'h7fff_ffff, 32'h8000_0000);
        push_query(32'h8000_0000, 32'h7fff_ffff, 32'h0000_4000, 32'hffff_c000);
        push_query(32'h7fff_ffff, 32'h8000_0000, 32'h0000_2000, 32'h0000_0000);
        push_query(0, 0, 32'h0000_0040, 32'hffff_f000);   // start just above a floor
        push_query(0, 0, 32'h0000_1000, 32'hffff_0000);   // start exactly on a floor
        push_query(0, 0, 32'hffff_0000, 32'h0001_0000);   // upward segment
        push_query(0, 0, 32'h0000_5000, 32'h0000_5000);   // zero length
        push_query(0, 0, 32'h0000_0100, 32'h0000_0090);   // ends just beyond tolerance above floor
        push_query(0, 0, 32'h0000_0300, 32'h0000_0200);   // ends above floor, too high
        push_write(63, 15, 32'hffff_ffff);
        push_write(63, 15, 32'h0);
        drain();
        set_reg(CFG_FACE_COUNT, 16'd0);
        push_query(0, 0, 32'h0001_0000, 32'hffff_0000);
        drain();

        random_phase(8, 16'h1, 16'h2, 40);
        random_phase(64, 16'h1, 16'h2, 15);
        random_phase(127, 16'h0, 16'h0, 10);
        random_phase(16, 16'h0, 16'hffff, 25);
        random_phase(12, 16'hffff, 16'h0, 15);
        random_phase(1, 16'h0, 16'h2, 10);
        random_phase(10, 16'($urandom), 16'($urandom), 20);

        if (errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
+incdir+rtl/core
rtl/core/vrfi_pkg.sv
rtl/core/vrfi_ram.sv
rtl/core/vertical_ray_face_intersect.sv
tb/vertical_ray_face_intersect_tb.sv
